[hdl/tlf_pkg.sv]
package tlf_pkg;

  // Block scaling brings the largest component magnitude into [2^29, 2^30).
  localparam int MANT_HI = 30;
  localparam int MANT_LO = 29;

  // Signed width of a block scaled component and of an exact cross product.
  localparam int MW = MANT_HI + 1;
  localparam int XW = 2 * MW;

  // Sum of three squared mantissas, and the number of square root steps.
  localparam int SQ_W       = 2 * MANT_HI + 2;
  localparam int ROOT_STEPS = MANT_HI + 1;

  // Bits of the centroid dividend retired per pipeline stage, and the divisor.
  localparam int DIV3_BITS = 8;
  localparam logic [2:0] CEN_DIV = 3'd3;

  typedef logic signed [MW-1:0] mant_t;
  typedef logic signed [XW-1:0] cross_t;
  typedef logic [MANT_HI-1:0]   mag_t;
  typedef logic [SQ_W-1:0]      sq_t;
  typedef logic [1:0]           rem3_t;

endpackage

[hdl/tlf_div3.sv]
module tlf_div3 #(
  parameter int CW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [CW+1:0]     in_sum [3],
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_valid,
  output logic signed [CW-1:0]     out_quo [3],
  output logic        [SIDE_W-1:0] out_side
);

  localparam int MB = CW + 1;
  localparam int ND = (MB + tlf_pkg::DIV3_BITS - 1) / tlf_pkg::DIV3_BITS;
  localparam int PW = ND * tlf_pkg::DIV3_BITS;

  logic [CW+1:0]         amag [3];
  logic [PW-1:0]         dnum [ND+1][3];
  logic [PW-1:0]         dquo [ND+1][3];
  tlf_pkg::rem3_t        drem [ND+1][3];
  logic                  dneg [ND+1][3];
  logic [SIDE_W-1:0]     dside [ND+1];
  logic                  dv [ND+1];
  logic [PW-1:0]         num_next [ND][3];
  logic [PW-1:0]         quo_next [ND][3];
  tlf_pkg::rem3_t        rem_next [ND][3];

  // Magnitude of each sum; rounding adds one before the floor division.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = in_sum[i][CW+1] ? (CW+2)'(-in_sum[i]) : (CW+2)'(in_sum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dnum[0][i] <= PW'(MB'(amag[i] + (CW+2)'(1)));
      dquo[0][i] <= '0;
      drem[0][i] <= '0;
      dneg[0][i] <= in_sum[i][CW+1];
    end
    dside[0] <= in_side;
  end

  // Long division by three, a fixed group of dividend bits per stage.
  for (genvar k = 0; k < ND; k++) begin : g_step
    always_comb begin
      tlf_pkg::rem3_t r;
      logic [PW-1:0]  n;
      logic [PW-1:0]  q;
      logic [2:0]     t;
      for (int i = 0; i < 3; i++) begin
        r = drem[k][i];
        n = dnum[k][i];
        q = dquo[k][i];
        for (int j = 0; j < tlf_pkg::DIV3_BITS; j++) begin
          t = {r, n[PW-1]};
          n = n << 1;
          if (t >= tlf_pkg::CEN_DIV) begin
            q = {q[PW-2:0], 1'b1};
            r = 2'(t - tlf_pkg::CEN_DIV);
          end else begin
            q = {q[PW-2:0], 1'b0};
            r = t[1:0];
          end
        end
        num_next[k][i] = n;
        quo_next[k][i] = q;
        rem_next[k][i] = r;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dnum[k+1][i] <= num_next[k][i];
        dquo[k+1][i] <= quo_next[k][i];
        drem[k+1][i] <= rem_next[k][i];
        dneg[k+1][i] <= dneg[k][i];
      end
      dside[k+1] <= dside[k];
    end
  end

  // Restore the sign of the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[ND];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] qv;
    for (int i = 0; i < 3; i++) begin
      qv = dquo[ND][i][CW-1:0];
      out_quo[i] <= dneg[ND][i] ? -qv : qv;
    end
    out_side <= dside[ND];
  end

endmodule

[hdl/tlf_bscale.sv]
module tlf_bscale #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [IN_W-1:0]   in_vec [3],
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_valid,
  output tlf_pkg::mant_t           out_vec [3],
  output logic        [SIDE_W-1:0] out_side
);

  localparam int LW = $clog2(IN_W);
  localparam int TW = (IN_W > tlf_pkg::MANT_HI) ? IN_W : tlf_pkg::MANT_HI;

  logic                v1;
  logic                v2;
  logic [IN_W-1:0]     mag1 [3];
  logic [IN_W-1:0]     mag2 [3];
  logic                neg1 [3];
  logic                neg2 [3];
  logic [SIDE_W-1:0]   side1;
  logic [SIDE_W-1:0]   side2;
  logic [IN_W-1:0]     any_bits;
  logic [LW-1:0]       lead2;
  logic [LW-1:0]       lead_next;
  tlf_pkg::mant_t      vec_next [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Split each component into sign and magnitude.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1[i] <= in_vec[i][IN_W-1];
      mag1[i] <= in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
    end
    side1 <= in_side;
  end

  // The leading one of the OR of the magnitudes is that of the largest one.
  always_comb begin
    any_bits  = mag1[0] | mag1[1] | mag1[2];
    lead_next = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (any_bits[k]) begin
        lead_next = LW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    lead2 <= lead_next;
    mag2  <= mag1;
    neg2  <= neg1;
    side2 <= side1;
  end

  // Shift all magnitudes by the same amount and put the sign back.
  always_comb begin
    logic [TW-1:0]  wide;
    tlf_pkg::mant_t m;
    for (int i = 0; i < 3; i++) begin
      if (int'(lead2) >= tlf_pkg::MANT_LO) begin
        wide = TW'(mag2[i]) >> (int'(lead2) - tlf_pkg::MANT_LO);
      end else begin
        wide = TW'(mag2[i]) << (tlf_pkg::MANT_LO - int'(lead2));
      end
      m           = {1'b0, wide[tlf_pkg::MANT_HI-1:0]};
      vec_next[i] = neg2[i] ? -m : m;
    end
  end

  always_ff @(posedge clk) begin
    out_vec  <= vec_next;
    out_side <= side2;
  end

endmodule

[hdl/tlf_cross.sv]
module tlf_cross #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tlf_pkg::mant_t       in_a [3],
  input  tlf_pkg::mant_t       in_b [3],
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output tlf_pkg::cross_t      out_vec [3],
  output logic [SIDE_W-1:0]    out_side
);

  logic                v1;
  tlf_pkg::cross_t     prod [6];
  logic [SIDE_W-1:0]   side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Six exact partial products.
  always_ff @(posedge clk) begin
    prod[0] <= in_a[1] * in_b[2];
    prod[1] <= in_a[2] * in_b[1];
    prod[2] <= in_a[2] * in_b[0];
    prod[3] <= in_a[0] * in_b[2];
    prod[4] <= in_a[0] * in_b[1];
    prod[5] <= in_a[1] * in_b[0];
    side1   <= in_side;
  end

  // Differences give the cross product components.
  always_ff @(posedge clk) begin
    out_vec[0] <= prod[0] - prod[1];
    out_vec[1] <= prod[2] - prod[3];
    out_vec[2] <= prod[4] - prod[5];
    out_side   <= side1;
  end

endmodule

[hdl/tlf_unit.sv]
module tlf_unit #(
  parameter int IN_W   = 62,
  parameter int AF     = 14,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [IN_W-1:0]   in_vec [3],
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_valid,
  output logic signed [AF+1:0]     out_axis [3],
  output logic        [SIDE_W-1:0] out_side
);

  localparam int QW = AF + 1;
  localparam int AW = AF + 2;
  localparam int DW = AF + tlf_pkg::MANT_HI + 3;
  localparam int NR = tlf_pkg::ROOT_STEPS;
  localparam int DS = AF + 1;

  logic                c_valid;
  tlf_pkg::mant_t      c_vec [3];
  logic [SIDE_W-1:0]   c_side;

  tlf_pkg::mag_t       mag_next [3];
  logic                u1v;
  tlf_pkg::mag_t       umag1 [3];
  logic                uneg1 [3];
  logic [SIDE_W-1:0]   side1;
  logic                u2v;
  tlf_pkg::mag_t       umag2 [3];
  logic                uneg2 [3];
  tlf_pkg::sq_t        sq2 [3];
  logic                zero2;
  logic [SIDE_W-1:0]   side2;

  tlf_pkg::sq_t        rs [NR+1];
  tlf_pkg::sq_t        rr [NR+1];
  tlf_pkg::mag_t       rmag [NR+1][3];
  logic                rneg [NR+1][3];
  logic                rzero [NR+1];
  logic [SIDE_W-1:0]   rside [NR+1];
  logic                rv [NR+1];

  logic [DW-1:0]       drem [DS+1][3];
  logic [QW-1:0]       dquo [DS+1][3];
  logic [DW-1:0]       dden [DS+1];
  logic                dneg [DS+1][3];
  logic                dzero [DS+1];
  logic [SIDE_W-1:0]   dside [DS+1];
  logic                dv [DS+1];

  // Block scale the vector first.
  tlf_bscale #(
    .IN_W   (IN_W),
    .SIDE_W (SIDE_W)
  ) u_bscale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_vec    (in_vec),
    .in_side   (in_side),
    .out_valid (c_valid),
    .out_vec   (c_vec),
    .out_side  (c_side)
  );

  // Magnitudes of the scaled components.
  always_comb begin
    tlf_pkg::mant_t nc;
    for (int i = 0; i < 3; i++) begin
      nc          = -c_vec[i];
      mag_next[i] = c_vec[i][tlf_pkg::MW-1] ? nc[tlf_pkg::MANT_HI-1:0]
                                            : c_vec[i][tlf_pkg::MANT_HI-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u1v   <= 1'b0;
      u2v   <= 1'b0;
      rv[0] <= 1'b0;
    end else begin
      u1v   <= c_valid;
      u2v   <= u1v;
      rv[0] <= u2v;
    end
  end

  // Squares, then their sum starts the square root.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      umag1[i] <= mag_next[i];
      uneg1[i] <= c_vec[i][tlf_pkg::MW-1];
      sq2[i]   <= umag1[i] * umag1[i];
    end
    side1    <= c_side;
    umag2    <= umag1;
    uneg2    <= uneg1;
    zero2    <= ~|{umag1[0], umag1[1], umag1[2]};
    side2    <= side1;
    rs[0]    <= sq2[0] + sq2[1] + sq2[2];
    rr[0]    <= '0;
    rmag[0]  <= umag2;
    rneg[0]  <= uneg2;
    rzero[0] <= zero2;
    rside[0] <= side2;
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < NR; k++) begin : g_root
    localparam tlf_pkg::sq_t RBIT = tlf_pkg::sq_t'(1) << (2 * (NR - 1 - k));

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rs[k] >= rr[k] + RBIT) begin
        rs[k+1] <= rs[k] - (rr[k] + RBIT);
        rr[k+1] <= (rr[k] >> 1) + RBIT;
      end else begin
        rs[k+1] <= rs[k];
        rr[k+1] <= rr[k] >> 1;
      end
      rmag[k+1]  <= rmag[k];
      rneg[k+1]  <= rneg[k];
      rzero[k+1] <= rzero[k];
      rside[k+1] <= rside[k];
    end
  end

  // Dividend 2*|c|*2^F + r and divisor 2*r for rounding half up.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= rv[NR];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      drem[0][i] <= (DW'(rmag[NR][i]) << QW) + DW'(rr[NR][tlf_pkg::MW-1:0]);
      dquo[0][i] <= '0;
    end
    dden[0]  <= DW'(rr[NR][tlf_pkg::MW-1:0]) << 1;
    dneg[0]  <= rneg[NR];
    dzero[0] <= rzero[NR];
    dside[0] <= rside[NR];
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < DS; k++) begin : g_div
    localparam int SH = AF - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (drem[k][i] >= (dden[k] << SH)) begin
          drem[k+1][i] <= drem[k][i] - (dden[k] << SH);
          dquo[k+1][i] <= {dquo[k][i][QW-2:0], 1'b1};
        end else begin
          drem[k+1][i] <= drem[k][i];
          dquo[k+1][i] <= {dquo[k][i][QW-2:0], 1'b0};
        end
      end
      dden[k+1]  <= dden[k];
      dneg[k+1]  <= dneg[k];
      dzero[k+1] <= dzero[k];
      dside[k+1] <= dside[k];
    end
  end

  // Signed axis; a zero-length vector gives a zero axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[DS];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [AW-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs = {1'b0, dquo[DS][i]};
      if (dzero[DS]) begin
        out_axis[i] <= '0;
      end else begin
        out_axis[i] <= dneg[DS][i] ? -qs : qs;
      end
    end
    out_side <= dside[DS];
  end

endmodule

[hdl/triangle_local_frame.sv]
// Pipeline from start to done: input stage, divide by three for the centroid, block scaling
// of the edges, normal cross product, its block scaling, bitangent cross product, and the
// unit vector stage with its 31-step square root and one-bit-per-stage divider.
// Throughput: one triangle per cycle; busy is always low and done strobes for one cycle.
// Reset: synchronous rst clears every stage valid bit, so no done follows reset.
// The receiver cannot stall; results leave the pipeline in the order they entered.
module triangle_local_frame #(
  parameter int COORD_WIDTH    = 32,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    v0_x,
  input  logic signed [COORD_WIDTH-1:0]    v0_y,
  input  logic signed [COORD_WIDTH-1:0]    v0_z,
  input  logic signed [COORD_WIDTH-1:0]    v1_x,
  input  logic signed [COORD_WIDTH-1:0]    v1_y,
  input  logic signed [COORD_WIDTH-1:0]    v1_z,
  input  logic signed [COORD_WIDTH-1:0]    v2_x,
  input  logic signed [COORD_WIDTH-1:0]    v2_y,
  input  logic signed [COORD_WIDTH-1:0]    v2_z,
  output logic                             done,
  output logic signed [COORD_WIDTH-1:0]    centroid_x,
  output logic signed [COORD_WIDTH-1:0]    centroid_y,
  output logic signed [COORD_WIDTH-1:0]    centroid_z,
  output logic signed [AXIS_FRAC_BITS+1:0] tangent_x,
  output logic signed [AXIS_FRAC_BITS+1:0] tangent_y,
  output logic signed [AXIS_FRAC_BITS+1:0] tangent_z,
  output logic signed [AXIS_FRAC_BITS+1:0] bitangent_x,
  output logic signed [AXIS_FRAC_BITS+1:0] bitangent_y,
  output logic signed [AXIS_FRAC_BITS+1:0] bitangent_z,
  output logic signed [AXIS_FRAC_BITS+1:0] normal_x,
  output logic signed [AXIS_FRAC_BITS+1:0] normal_y,
  output logic signed [AXIS_FRAC_BITS+1:0] normal_z
);

  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW + 1;
  localparam int SW    = CW + 2;
  localparam int AW    = AXIS_FRAC_BITS + 2;
  localparam int MW    = tlf_pkg::MW;
  localparam int CEN_W = 3 * CW;
  localparam int E_W   = 3 * MW;
  localparam int DIV3_STAGES = (CW + tlf_pkg::DIV3_BITS) / tlf_pkg::DIV3_BITS;
  localparam int LATENCY     = DIV3_STAGES + AXIS_FRAC_BITS + 53;
  localparam logic signed [AW-1:0] AXIS_ONE = AW'(1 << AXIS_FRAC_BITS);

  logic                     in_v;
  logic signed [EW-1:0]     e0 [3];
  logic signed [EW-1:0]     e1 [3];
  logic signed [SW-1:0]     csum [3];

  logic                     d3_valid;
  logic signed [CW-1:0]     cq [3];
  logic [6*EW-1:0]          d3_side;
  logic signed [EW-1:0]     e0d [3];
  logic signed [EW-1:0]     e1d [3];

  logic                     bs0_valid;
  tlf_pkg::mant_t           e0s [3];
  tlf_pkg::mant_t           e1s [3];
  logic [CEN_W-1:0]         bs0_side;

  logic                     x1_valid;
  tlf_pkg::cross_t          nraw [3];
  logic [CEN_W+E_W-1:0]     x1_side;

  logic                     bsn_valid;
  tlf_pkg::mant_t           ns [3];
  logic [CEN_W+E_W-1:0]     bsn_side;
  tlf_pkg::mant_t           e0s1 [3];

  logic                     x2_valid;
  tlf_pkg::cross_t          braw [3];
  logic [CEN_W+2*E_W-1:0]   x2_side;
  tlf_pkg::mant_t           e0s2 [3];
  tlf_pkg::mant_t           ns2 [3];

  logic signed [AW-1:0]     tan [3];
  logic signed [AW-1:0]     nrm [3];
  logic signed [AW-1:0]     bit_axis [3];
  logic [CEN_W-1:0]         cen_out;

  // The pipeline never holds requests off.
  assign busy = 1'b0;

  // Input stage: edges and vertex sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    e0[0]   <= EW'(v1_x) - EW'(v0_x);
    e0[1]   <= EW'(v1_y) - EW'(v0_y);
    e0[2]   <= EW'(v1_z) - EW'(v0_z);
    e1[0]   <= EW'(v2_x) - EW'(v1_x);
    e1[1]   <= EW'(v2_y) - EW'(v1_y);
    e1[2]   <= EW'(v2_z) - EW'(v1_z);
    csum[0] <= SW'(v0_x) + SW'(v1_x) + SW'(v2_x);
    csum[1] <= SW'(v0_y) + SW'(v1_y) + SW'(v2_y);
    csum[2] <= SW'(v0_z) + SW'(v1_z) + SW'(v2_z);
  end

  // Centroid first; the edges ride along.
  tlf_div3 #(
    .CW     (CW),
    .SIDE_W (6 * EW)
  ) u_div3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_v),
    .in_sum    (csum),
    .in_side   ({e0[0], e0[1], e0[2], e1[0], e1[1], e1[2]}),
    .out_valid (d3_valid),
    .out_quo   (cq),
    .out_side  (d3_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0d[i] = d3_side[(6-i)*EW-1 -: EW];
      e1d[i] = d3_side[(3-i)*EW-1 -: EW];
    end
  end

  // Both edges are block scaled side by side.
  tlf_bscale #(
    .IN_W   (EW),
    .SIDE_W (CEN_W)
  ) u_bs_e0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d3_valid),
    .in_vec    (e0d),
    .in_side   ({cq[0], cq[1], cq[2]}),
    .out_valid (bs0_valid),
    .out_vec   (e0s),
    .out_side  (bs0_side)
  );

  tlf_bscale #(
    .IN_W   (EW),
    .SIDE_W (1)
  ) u_bs_e1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d3_valid),
    .in_vec    (e1d),
    .in_side   (1'b0),
    .out_valid (),
    .out_vec   (e1s),
    .out_side  ()
  );

  // Raw normal from the scaled edges.
  tlf_cross #(
    .SIDE_W (CEN_W + E_W)
  ) u_cross_n (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bs0_valid),
    .in_a      (e0s),
    .in_b      (e1s),
    .in_side   ({bs0_side, e0s[0], e0s[1], e0s[2]}),
    .out_valid (x1_valid),
    .out_vec   (nraw),
    .out_side  (x1_side)
  );

  tlf_bscale #(
    .IN_W   (tlf_pkg::XW),
    .SIDE_W (CEN_W + E_W)
  ) u_bs_n (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x1_valid),
    .in_vec    (nraw),
    .in_side   (x1_side),
    .out_valid (bsn_valid),
    .out_vec   (ns),
    .out_side  (bsn_side)
  );

  // The scaled first edge that travelled alongside the normal.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0s1[i] = bsn_side[E_W-1-i*MW -: MW];
    end
  end

  // Raw bitangent from the scaled normal and the scaled first edge.
  tlf_cross #(
    .SIDE_W (CEN_W + 2 * E_W)
  ) u_cross_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bsn_valid),
    .in_a      (ns),
    .in_b      (e0s1),
    .in_side   ({bsn_side, ns[0], ns[1], ns[2]}),
    .out_valid (x2_valid),
    .out_vec   (braw),
    .out_side  (x2_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0s2[i] = x2_side[2*E_W-1-i*MW -: MW];
      ns2[i]  = x2_side[E_W-1-i*MW -: MW];
    end
  end

  // Three unit vector pipelines run in lockstep.
  tlf_unit #(
    .IN_W   (MW),
    .AF     (AXIS_FRAC_BITS),
    .SIDE_W (CEN_W)
  ) u_unit_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x2_valid),
    .in_vec    (e0s2),
    .in_side   (x2_side[CEN_W+2*E_W-1 -: CEN_W]),
    .out_valid (done),
    .out_axis  (tan),
    .out_side  (cen_out)
  );

  tlf_unit #(
    .IN_W   (MW),
    .AF     (AXIS_FRAC_BITS),
    .SIDE_W (1)
  ) u_unit_n (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x2_valid),
    .in_vec    (ns2),
    .in_side   (1'b0),
    .out_valid (),
    .out_axis  (nrm),
    .out_side  ()
  );

  tlf_unit #(
    .IN_W   (tlf_pkg::XW),
    .AF     (AXIS_FRAC_BITS),
    .SIDE_W (1)
  ) u_unit_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x2_valid),
    .in_vec    (braw),
    .in_side   (1'b0),
    .out_valid (),
    .out_axis  (bit_axis),
    .out_side  ()
  );

  // Result ports.
  assign centroid_x  = cen_out[CEN_W-1 -: CW];
  assign centroid_y  = cen_out[2*CW-1 -: CW];
  assign centroid_z  = cen_out[CW-1:0];
  assign tangent_x   = tan[0];
  assign tangent_y   = tan[1];
  assign tangent_z   = tan[2];
  assign normal_x    = nrm[0];
  assign normal_y    = nrm[1];
  assign normal_z    = nrm[2];
  assign bitangent_x = bit_axis[0];
  assign bitangent_y = bit_axis[1];
  assign bitangent_z = bit_axis[2];

`ifndef ASSERT_OFF
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted request did not complete after the pipeline latency");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  a_degenerate_frame: assert property (@(posedge clk) disable iff (rst)
    done && tangent_x == 0 && tangent_y == 0 && tangent_z == 0 |->
      normal_x == 0 && normal_y == 0 && normal_z == 0 &&
      bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0)
    else $error("zero tangent with a nonzero normal or bitangent");

  a_normal_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x <= AXIS_ONE && normal_x >= -AXIS_ONE &&
             normal_y <= AXIS_ONE && normal_y >= -AXIS_ONE &&
             normal_z <= AXIS_ONE && normal_z >= -AXIS_ONE)
    else $error("normal component exceeds unit magnitude");
`endif

endmodule

[sim/triangle_frame_checker.sv]
`timescale 1ns / 100ps

module triangle_frame_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] v0_x,
  input  logic signed [31:0] v0_y,
  input  logic signed [31:0] v0_z,
  input  logic signed [31:0] v1_x,
  input  logic signed [31:0] v1_y,
  input  logic signed [31:0] v1_z,
  input  logic signed [31:0] v2_x,
  input  logic signed [31:0] v2_y,
  input  logic signed [31:0] v2_z,
  input  logic               done,
  input  logic signed [31:0] centroid_x,
  input  logic signed [31:0] centroid_y,
  input  logic signed [31:0] centroid_z,
  input  logic signed [15:0] tangent_x,
  input  logic signed [15:0] tangent_y,
  input  logic signed [15:0] tangent_z,
  input  logic signed [15:0] bitangent_x,
  input  logic signed [15:0] bitangent_y,
  input  logic signed [15:0] bitangent_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output int                 error_count,
  output int                 pending,
  output int                 request_count,
  output int                 frame_count,
  output int                 degenerate_count
);

  localparam int FRAC = 14;

  typedef logic signed [63:0] wide_t;
  typedef wide_t vec_t [3];

  typedef struct {
    logic signed [31:0] cen [3];
    logic signed [15:0] tan [3];
    logic signed [15:0] bit3 [3];
    logic signed [15:0] nrm [3];
  } frame_t;

  frame_t expected_frames [$];

  // Magnitude of a 64-bit signed value as unsigned.
  function automatic logic [63:0] magnitude(wide_t v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Shift a vector so its largest magnitude lies in [2^29, 2^30).
  function automatic vec_t normalize_exponent(vec_t v);
    logic [63:0] m;
    logic [63:0] a;
    int up;
    int down;
    vec_t r;
    m = 0;
    up = 0;
    down = 0;
    for (int i = 0; i < 3; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
    if (m == 0) return v;
    while ((m >> down) >= (64'd1 << 30)) down++;
    while ((m << up) < (64'd1 << 29)) up++;
    for (int i = 0; i < 3; i++) begin
      a = (magnitude(v[i]) >> down) << up;
      r[i] = v[i] < 0 ? -wide_t'(a) : wide_t'(a);
    end
    return r;
  endfunction

  function automatic vec_t cross_product(vec_t a, vec_t b);
    vec_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Unit vector in Q1.14, rounded half up in magnitude; zero stays zero.
  function automatic vec_t unit_axis(vec_t v);
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] q;
    vec_t o;
    v = normalize_exponent(v);
    s = 0;
    for (int i = 0; i < 3; i++) s += magnitude(v[i]) * magnitude(v[i]);
    if (s == 0) begin
      o[0] = 0;
      o[1] = 0;
      o[2] = 0;
      return o;
    end
    r = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      a = magnitude(v[i]) << FRAC;
      q = (2 * a + r) / (2 * r);
      o[i] = v[i] < 0 ? -wide_t'(q) : wide_t'(q);
    end
    return o;
  endfunction

  function automatic frame_t predict_frame(vec_t p0, vec_t p1, vec_t p2);
    frame_t f;
    vec_t e0;
    vec_t e1;
    vec_t n;
    vec_t b;
    vec_t t;
    wide_t sum;
    logic [63:0] q;
    for (int i = 0; i < 3; i++) begin
      sum = p0[i] + p1[i] + p2[i];
      q = (magnitude(sum) + 1) / 3;
      f.cen[i] = sum < 0 ? 32'(-wide_t'(q)) : 32'(q);
      e0[i] = p1[i] - p0[i];
      e1[i] = p2[i] - p1[i];
    end
    e0 = normalize_exponent(e0);
    e1 = normalize_exponent(e1);
    n = cross_product(e0, e1);
    b = cross_product(normalize_exponent(n), e0);
    t = unit_axis(e0);
    n = unit_axis(n);
    b = unit_axis(b);
    for (int i = 0; i < 3; i++) begin
      f.tan[i] = 16'(t[i]);
      f.bit3[i] = 16'(b[i]);
      f.nrm[i] = 16'(n[i]);
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Predict on each accepted request.
  always @(posedge clk) begin
    vec_t p0;
    vec_t p1;
    vec_t p2;
    frame_t f;
    if (!rst && start && !busy) begin
      p0[0] = v0_x; p0[1] = v0_y; p0[2] = v0_z;
      p1[0] = v1_x; p1[1] = v1_y; p1[2] = v1_z;
      p2[0] = v2_x; p2[1] = v2_y; p2[2] = v2_z;
      f = predict_frame(p0, p1, p2);
      if (f.nrm[0] == 0 && f.nrm[1] == 0 && f.nrm[2] == 0) degenerate_count++;
      expected_frames.insert(expected_frames.size(), f);
      request_count++;
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    frame_t w;
    if (!rst && done) begin
      frame_count++;
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_frames.pop_front();
        if (centroid_x != w.cen[0]) report_mismatch("centroid_x", centroid_x, w.cen[0]);
        if (centroid_y != w.cen[1]) report_mismatch("centroid_y", centroid_y, w.cen[1]);
        if (centroid_z != w.cen[2]) report_mismatch("centroid_z", centroid_z, w.cen[2]);
        if (tangent_x != w.tan[0]) report_mismatch("tangent_x", tangent_x, w.tan[0]);
        if (tangent_y != w.tan[1]) report_mismatch("tangent_y", tangent_y, w.tan[1]);
        if (tangent_z != w.tan[2]) report_mismatch("tangent_z", tangent_z, w.tan[2]);
        if (bitangent_x != w.bit3[0]) report_mismatch("bitangent_x", bitangent_x, w.bit3[0]);
        if (bitangent_y != w.bit3[1]) report_mismatch("bitangent_y", bitangent_y, w.bit3[1]);
        if (bitangent_z != w.bit3[2]) report_mismatch("bitangent_z", bitangent_z, w.bit3[2]);
        if (normal_x != w.nrm[0]) report_mismatch("normal_x", normal_x, w.nrm[0]);
        if (normal_y != w.nrm[1]) report_mismatch("normal_y", normal_y, w.nrm[1]);
        if (normal_z != w.nrm[2]) report_mismatch("normal_z", normal_z, w.nrm[2]);
      end
    end
  end

  // Requests still waiting for their result.
  assign pending = request_count - frame_count;

  initial begin
    error_count = 0;
    request_count = 0;
    frame_count = 0;
    degenerate_count = 0;
  end

endmodule

[sim/triangle_local_frame_test.sv]
`timescale 1ns / 100ps

module triangle_local_frame_test;

  localparam int RANDOM_REQUESTS = 1880;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic signed [31:0] v [9];
  logic signed [31:0] centroid_x, centroid_y, centroid_z;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic signed [15:0] bitangent_x, bitangent_y, bitangent_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  int error_count;
  int pending;
  int request_count;
  int frame_count;
  int degenerate_count;
  int idle_cycles;

  triangle_local_frame dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(v[0]), .v0_y(v[1]), .v0_z(v[2]),
    .v1_x(v[3]), .v1_y(v[4]), .v1_z(v[5]),
    .v2_x(v[6]), .v2_y(v[7]), .v2_z(v[8]),
    .done(done),
    .centroid_x(centroid_x), .centroid_y(centroid_y), .centroid_z(centroid_z),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

  triangle_frame_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(v[0]), .v0_y(v[1]), .v0_z(v[2]),
    .v1_x(v[3]), .v1_y(v[4]), .v1_z(v[5]),
    .v2_x(v[6]), .v2_y(v[7]), .v2_z(v[8]),
    .done(done),
    .centroid_x(centroid_x), .centroid_y(centroid_y), .centroid_z(centroid_z),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .error_count(error_count), .pending(pending), .request_count(request_count),
    .frame_count(frame_count), .degenerate_count(degenerate_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Random coordinate, biased toward extremes and small values.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  // Present one request and hold it until accepted.
  task automatic send_request(logic [31:0] c [9]);
    for (int i = 0; i < 9; i++) v[i] <= c[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    logic [31:0] c [9];
    int burst;
    int shape;
    rst = 1'b1;
    start = 1'b0;
    idle_cycles = 0;
    for (int i = 0; i < 9; i++) v[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, coincident vertices, collinear edges, axis-aligned triangles.
    for (int k = 0; k < 22; k++) begin
      for (int i = 0; i < 9; i++) c[i] = 0;
      case (k)
        0: ;
        1: for (int i = 0; i < 9; i++) c[i] = 32'h7fff_ffff;
        2: for (int i = 0; i < 9; i++) c[i] = 32'h8000_0000;
        3: begin c[3] = 32'h0001_0000; c[7] = 32'h0001_0000; end
        4: begin c[3] = 32'h8000_0000; c[7] = 32'h7fff_ffff; end
        5: begin c[0] = 32'h8000_0000; c[3] = 32'h7fff_ffff; c[8] = 32'h7fff_ffff; end
        6: begin c[3] = 1; c[6] = 2; end
        7: begin c[3] = 32'h7fff_ffff; c[4] = 32'h7fff_ffff; c[6] = 32'h8000_0000;
                 c[7] = 32'h8000_0000; end
        8: begin c[3] = 1; c[7] = 1; end
        9: begin c[4] = 3; c[5] = 1; c[7] = 6; c[8] = 2; end
        10: for (int i = 0; i < 9; i++) c[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        11: begin c[0] = 5; c[1] = 5; c[2] = 5; c[3] = 5; c[4] = 5; c[5] = 5; c[8] = 9; end
        12: begin c[0] = 1; c[1] = 1; c[2] = 1; end
        13: begin c[0] = 32'hffff_ffff; c[3] = 32'hffff_fffe; c[7] = 32'hffff_ffff; end
        14: begin c[5] = 32'h4000_0000; c[6] = 32'hc000_0000; end
        default: for (int i = 0; i < 9; i++) c[i] = pick_coord();
      endcase
      send_request(c);
    end

    // Let everything drain once before the random part.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random bursts of triangles with gaps.
    for (int n = 0; n < RANDOM_REQUESTS; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < RANDOM_REQUESTS; j++, n++) begin
        for (int i = 0; i < 9; i++) c[i] = pick_coord();
        shape = $urandom_range(0, 9);
        // Occasionally make degenerate or collinear triangles.
        if (shape == 0) for (int i = 0; i < 3; i++) c[3 + i] = c[i];
        if (shape == 1) for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i] + (c[3 + i] - c[i]);
        if (shape == 2) for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
        send_request(c);
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
      if (n == RANDOM_REQUESTS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d triangles, checked %0d frames (%0d with a zero normal).",
             request_count, frame_count, degenerate_count);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tlf_pkg.sv
hdl/tlf_div3.sv
hdl/tlf_bscale.sv
hdl/tlf_cross.sv
hdl/tlf_unit.sv
hdl/triangle_local_frame.sv
sim/triangle_frame_checker.sv
sim/triangle_local_frame_test.sv
